### rtl/core/stereo_noise_gate_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo noise gate
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_NOISE_GATE_UNIT_ASSERT_SVH
`define STEREO_NOISE_GATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// A temporal property, typically written with |-> or |=>.
`define SNG_ASSERT_SEQ(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// A condition that must hold at every clock edge out of reset.
`define SNG_INVARIANT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`else

`define SNG_ASSERT_SEQ(label, prop, msg)
`define SNG_INVARIANT(label, expr, msg)

`endif

`endif

### rtl/core/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg
// Widths, fixed-point constants, register map and configuration type of the
// stereo noise gate.
// ----------------------------------------------------------------------------
package sng_pkg;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int THR_W          = 16;
	localparam int GAIN_W         = COEF_FRAC_BITS + 1;

	// The shared multiplier takes gain by coefficient and gain by level.
	localparam int MUL_W  = (GAIN_W > SAMPLE_WIDTH) ? GAIN_W : SAMPLE_WIDTH;
	localparam int PROD_W = GAIN_W + MUL_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int RND_W  = SUM_W - COEF_FRAC_BITS;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COEF_FRAC_BITS;

	typedef enum logic [2:0] {
		REG_OPEN_THR      = 3'd0,
		REG_CLOSE_THR     = 3'd1,
		REG_ATTACK_DECAY  = 3'd2,
		REG_RELEASE_DECAY = 3'd3,
		REG_ATTACK_STEP   = 3'd4,
		REG_RELEASE_STEP  = 3'd5,
		REG_BYPASS        = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]  open_threshold;
		logic [THR_W-1:0]  close_threshold;
		logic [GAIN_W-1:0] attack_decay;
		logic [GAIN_W-1:0] release_decay;
		logic [GAIN_W-1:0] attack_step;
		logic [GAIN_W-1:0] release_step;
		logic              bypass;
	} cfg_t;

endpackage

### rtl/core/sng_if.sv
// ----------------------------------------------------------------------------
// sng_in_if / sng_out_if
// Valid/ready channels for input samples and gated result samples.
// ----------------------------------------------------------------------------
interface sng_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [sng_pkg::SAMPLE_WIDTH-1:0]  sample_in;
	logic                                     channel;

	modport source (output valid, output sample_in, output channel, input ready);
	modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

interface sng_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [sng_pkg::SAMPLE_WIDTH-1:0]  sample_out;
	logic                                     channel_out;

	modport source (output valid, output sample_out, output channel_out, input ready);
	modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

### rtl/core/stereo_noise_gate_unit.sv
// ----------------------------------------------------------------------------
// stereo_noise_gate_unit
// Two-channel noise gate with hysteresis and a smoothed per-channel gain.
//
//   Port   Kind           Beat carries
//   in     valid/ready    sample_in, channel
//   out    valid/ready    sample_out, channel_out
//   APB    psel/penable   register write or read, pready always high
//
// A gated sample passes four steps: gain multiply, gain update, level multiply,
// round and clamp. The single 17x17 multiplier is used twice per gated sample;
// the next sample is taken in the cycle the result is loaded, and never while
// an earlier sample is still in its multiply or update steps. A bypassed sample
// goes straight to the final step. A result waits in the output register while
// out is stalled, and the unit holds its final step until that register frees
// up. Reset clears the gains, gate flags, output valid and config registers.
// ----------------------------------------------------------------------------
`include "stereo_noise_gate_unit_assert.svh"

module stereo_noise_gate_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sng_pkg::ADDR_W-1:0]  paddr,
	input  logic [sng_pkg::DATA_W-1:0]  pwdata,
	output logic [sng_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	sng_in_if.sink                      in,
	sng_out_if.source                   out
);
	import sng_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GAIN,
		S_UPD,
		S_LVL,
		S_FIN
	} state_t;

	localparam logic [RND_W-1:0] NEG_MAG = RND_W'(1) << (SAMPLE_WIDTH - 1);
	localparam logic [RND_W-1:0] POS_MAX = NEG_MAG - RND_W'(1);
	localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (COEF_FRAC_BITS - 1);

	cfg_t cfg;

	state_t                    state_q;
	logic [GAIN_W-1:0]         gain_q [2];
	logic [1:0]                gate_q;
	logic [SAMPLE_WIDTH-1:0]   smp_q;
	logic [SAMPLE_WIDTH-1:0]   lvl_q;
	logic                      ch_q;
	logic                      gate_new_q;
	logic                      byp_q;
	logic [PROD_W-1:0]         prod_q;
	logic [SAMPLE_WIDTH-1:0]   out_smp_q;
	logic                      out_ch_q;
	logic                      out_valid_q;

	logic [SAMPLE_WIDTH-1:0]   raw_in;
	logic [SAMPLE_WIDTH-1:0]   lvl_in;
	logic                      gate_cur;
	logic                      gate_nxt;
	logic                      fin_go;
	logic                      in_acc;
	logic [MUL_W-1:0]          mul_a;
	logic [PROD_W-1:0]         mul_p;
	logic [SUM_W-1:0]          step_sh;
	logic [SUM_W-1:0]          gsum;
	logic [RND_W-1:0]          graw;
	logic [GAIN_W-1:0]         gsat;
	logic [SUM_W-1:0]          rsum;
	logic [RND_W-1:0]          rmag;
	logic [RND_W-1:0]          rclamp;
	logic [SAMPLE_WIDTH-1:0]   res;

	sng_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Level is the magnitude; the most negative sample maps to 2^(W-1).
	assign raw_in   = in.sample_in;
	assign lvl_in   = raw_in[SAMPLE_WIDTH-1] ? (~raw_in + 1'b1) : raw_in;
	assign gate_cur = gate_q[in.channel];
	assign gate_nxt = gate_cur ? !(lvl_in <= cfg.close_threshold)
	                           : (lvl_in >= cfg.open_threshold);

	assign fin_go   = !out_valid_q || out.ready;
	assign in.ready = (state_q == S_IDLE) || ((state_q == S_FIN) && fin_go);
	assign in_acc   = in.valid && in.ready;

	// Shared multiplier: decay factor by old gain, then level by new gain.
	always_comb begin
		if (state_q == S_GAIN) begin
			mul_a = MUL_W'(gate_new_q ? cfg.attack_decay : cfg.release_decay);
		end else begin
			mul_a = MUL_W'(lvl_q);
		end
	end
	assign mul_p = mul_a * gain_q[ch_q];

	// Gain update: add the attack step while the gate is open, truncate, cap at one.
	assign step_sh = SUM_W'(cfg.attack_step) << COEF_FRAC_BITS;
	assign gsum    = SUM_W'(prod_q) + (gate_new_q ? step_sh : '0);
	assign graw    = gsum[SUM_W-1:COEF_FRAC_BITS];
	assign gsat    = (graw > RND_W'(GAIN_ONE)) ? GAIN_ONE : graw[GAIN_W-1:0];

	// Output: round the magnitude half up, clamp, restore the sign.
	assign rsum   = SUM_W'(prod_q) + HALF;
	assign rmag   = rsum[SUM_W-1:COEF_FRAC_BITS];
	always_comb begin
		if (smp_q[SAMPLE_WIDTH-1]) begin
			rclamp = (rmag > NEG_MAG) ? NEG_MAG : rmag;
			res    = ~rclamp[SAMPLE_WIDTH-1:0] + 1'b1;
		end else begin
			rclamp = (rmag > POS_MAX) ? POS_MAX : rmag;
			res    = rclamp[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gain_q      <= '{default: '0};
			gate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= cfg.bypass ? S_FIN : S_GAIN;
					end
				end
				S_GAIN: begin
					prod_q  <= mul_p;
					state_q <= S_UPD;
				end
				S_UPD: begin
					gain_q[ch_q] <= gsat;
					gate_q[ch_q] <= gate_new_q;
					state_q      <= S_LVL;
				end
				S_LVL: begin
					prod_q  <= mul_p;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						out_smp_q <= byp_q ? smp_q : res;
						out_ch_q  <= ch_q;
						// A new beat may be taken in the same cycle the result loads.
						if (in_acc) begin
							state_q <= cfg.bypass ? S_FIN : S_GAIN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: ;
			endcase
			if (in_acc) begin
				smp_q      <= raw_in;
				lvl_q      <= lvl_in;
				ch_q       <= in.channel;
				gate_new_q <= gate_nxt;
				byp_q      <= cfg.bypass;
			end
		end
	end

	assign out.valid       = out_valid_q;
	assign out.sample_out  = out_smp_q;
	assign out.channel_out = out_ch_q;

	`SNG_ASSERT_SEQ(a_gated_start, in_acc && !cfg.bypass |=> state_q == S_GAIN, "gated beat did not start the gain multiply")
	`SNG_ASSERT_SEQ(a_bypass_hold, in_acc && cfg.bypass |=> $stable(gain_q[0]) && $stable(gain_q[1]) && $stable(gate_q), "bypassed beat changed channel state")
	`SNG_ASSERT_SEQ(a_fin_loads, state_q == S_FIN && fin_go |=> out_valid_q, "final step did not load the output register")
	`SNG_INVARIANT(a_gain_cap, gain_q[0] <= GAIN_ONE && gain_q[1] <= GAIN_ONE, "channel gain above unity")

endmodule

### rtl/core/sng_regs.sv
// ----------------------------------------------------------------------------
// sng_regs
// APB register file holding thresholds, smoothing coefficients and bypass.
// ----------------------------------------------------------------------------
module sng_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sng_pkg::ADDR_W-1:0]  paddr,
	input  logic [sng_pkg::DATA_W-1:0]  pwdata,
	output logic [sng_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output sng_pkg::cfg_t               cfg
);
	import sng_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_OPEN_THR:      cfg_q.open_threshold  <= pwdata[THR_W-1:0];
				REG_CLOSE_THR:     cfg_q.close_threshold <= pwdata[THR_W-1:0];
				REG_ATTACK_DECAY:  cfg_q.attack_decay    <= pwdata[GAIN_W-1:0];
				REG_RELEASE_DECAY: cfg_q.release_decay   <= pwdata[GAIN_W-1:0];
				REG_ATTACK_STEP:   cfg_q.attack_step     <= pwdata[GAIN_W-1:0];
				REG_RELEASE_STEP:  cfg_q.release_step    <= pwdata[GAIN_W-1:0];
				REG_BYPASS:        cfg_q.bypass          <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OPEN_THR:      prdata = DATA_W'(cfg_q.open_threshold);
			REG_CLOSE_THR:     prdata = DATA_W'(cfg_q.close_threshold);
			REG_ATTACK_DECAY:  prdata = DATA_W'(cfg_q.attack_decay);
			REG_RELEASE_DECAY: prdata = DATA_W'(cfg_q.release_decay);
			REG_ATTACK_STEP:   prdata = DATA_W'(cfg_q.attack_step);
			REG_RELEASE_STEP:  prdata = DATA_W'(cfg_q.release_step);
			REG_BYPASS:        prdata = DATA_W'(cfg_q.bypass);
			default:           prdata = '0;
		endcase
	end

endmodule
